@@ src/irm_pkg.sv @@
// Types and constants shared by the I2C register access master.
package irm_pkg;

	typedef enum logic [14:0] {
		PH_IDLE = 15'b000000000000001,
		PH_ST1  = 15'b000000000000010,
		PH_ST2  = 15'b000000000000100,
		PH_ST3  = 15'b000000000001000,
		PH_RST  = 15'b000000000010000,
		PH_TXL  = 15'b000000000100000,
		PH_TXH  = 15'b000000001000000,
		PH_TXA  = 15'b000000010000000,
		PH_RXL  = 15'b000000100000000,
		PH_RXH  = 15'b000001000000000,
		PH_MAL  = 15'b000010000000000,
		PH_MAH  = 15'b000100000000000,
		PH_SP1  = 15'b001000000000000,
		PH_SP2  = 15'b010000000000000,
		PH_SP3  = 15'b100000000000000
	} phase_t;

	typedef enum logic [2:0] {
		K_AW = 3'd0,
		K_RH = 3'd1,
		K_RL = 3'd2,
		K_DW = 3'd3,
		K_AR = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	localparam logic [2:0] CFG_DEVICE_ADDRESS   = 3'd0;
	localparam logic [2:0] CFG_REGISTER_ADDRESS = 3'd1;
	localparam logic [2:0] CFG_WIDE_ADDRESS     = 3'd2;
	localparam logic [2:0] CFG_TRANSFER_LENGTH  = 3'd3;
	localparam logic [2:0] CFG_ACK_TIMEOUT      = 3'd4;

	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
	localparam logic [7:0] READ_BIT = 8'h01;

	typedef struct packed {
		logic [7:0]  device_address;
		logic [15:0] register_address;
		logic        wide_register_address;
		logic [7:0]  transfer_length;
		logic [7:0]  ack_timeout;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		kind_t      kind;
		logic       read_mode;
		logic [2:0] bit_cnt;
		logic [7:0] shreg;
		logic [7:0] byte_cnt;
		logic [7:0] wait_cnt;
	} seq_state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       tx_taken;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       busy_res;
		logic       done_res;
		logic [7:0] bytes_done;
		logic       fault;
	} result_t;

endpackage

@@ src/i2c_register_access_master.sv @@
// Top level of the I2C register access master: sequencer state and result register.
//
// Usage: each input item is one bus phase tick from a prescaler, carrying the
// requested action (plain tick, begin write, begin read), the sampled SDA level
// and the next write data byte. Each accepted item yields exactly one result
// item with the SCL/SDA levels to drive for that phase, the tx_taken and rx
// strobes, busy, done, the acknowledged byte count and the address fault flag.
// The result is registered and appears on the output in the cycle after its item is taken.
// Throughput: one item per cycle; the sequencer state and the result register
// both update in the accepting cycle, set by one pass through the step logic.
// The input side stays ready while the result register is empty or being
// drained, so a result waiting on a stalled receiver does not stop the
// next item as long as the receiver takes the waiting one in the same cycle.
// When the receiver stalls, the result holds and input accept stops.
// Reset clears the sequencer to idle (bus released, SCL high) and loads the
// register defaults; configuration is written through cfg_we/cfg_index/cfg_data.
module i2c_register_access_master import irm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic                  sda_sample,
	input  logic [7:0]            tx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  scl_level,
	output logic                  sda_level,
	output logic                  sda_drive,
	output logic                  tx_taken,
	output logic [7:0]            rx_byte,
	output logic                  rx_valid,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [7:0]            bytes_done,
	output logic                  fault
);

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    res_comb;
	result_t    res_s1;
	logic       valid_s1;
	logic       accept;

	irm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	irm_step u_step (
		.cur        (state_q),
		.cfg        (cfg),
		.action     (action),
		.sda_sample (sda_sample),
		.tx_byte    (tx_byte),
		.nxt        (state_nxt),
		.res        (res_comb)
	);

	assign in_ready = !valid_s1 || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.kind <= K_AW;
			state_q.read_mode <= 1'b0;
			state_q.bit_cnt <= '0;
			state_q.shreg <= '0;
			state_q.byte_cnt <= '0;
			state_q.wait_cnt <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			state_q <= state_nxt;
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_comb;
		end
	end

	assign out_valid = valid_s1;
	assign scl_level = res_s1.scl_level;
	assign sda_level = res_s1.sda_level;
	assign sda_drive = res_s1.sda_drive;
	assign tx_taken = res_s1.tx_taken;
	assign rx_byte = res_s1.rx_byte;
	assign rx_valid = res_s1.rx_valid;
	assign busy_res = res_s1.busy_res;
	assign done_res = res_s1.done_res;
	assign bytes_done = res_s1.bytes_done;
	assign fault = res_s1.fault;

endmodule

@@ src/irm_cfg_regs.sv @@
// Configuration register file of the I2C register access master.
module irm_cfg_regs import irm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= '0;
			cfg_q.register_address <= '0;
			cfg_q.wide_register_address <= 1'b0;
			cfg_q.transfer_length <= '0;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[7:0];
				CFG_REGISTER_ADDRESS: cfg_q.register_address <= cfg_data[15:0];
				CFG_WIDE_ADDRESS: cfg_q.wide_register_address <= cfg_data[0];
				CFG_TRANSFER_LENGTH: cfg_q.transfer_length <= cfg_data[7:0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/irm_step.sv @@
// Next-state and bus phase logic for one tick of the I2C sequencer.
module irm_step import irm_pkg::*; (
	input  seq_state_t cur,
	input  cfg_t       cfg,
	input  logic [1:0] action,
	input  logic       sda_sample,
	input  logic [7:0] tx_byte,
	output seq_state_t nxt,
	output result_t    res
);

	always_comb begin
		seq_state_t s;
		logic [7:0] byte_inc;
		logic [7:0] rx_shift;
		logic       mack_nack;

		s = cur;
		res = '0;
		res.scl_level = 1'b1;
		res.sda_level = 1'b1;

		if (cur.phase == PH_IDLE && (action == ACT_WRITE || action == ACT_READ)) begin
			s.read_mode = (action == ACT_READ);
			s.bit_cnt = '0;
			s.byte_cnt = '0;
			s.wait_cnt = '0;
			s.shreg = '0;
			s.phase = PH_ST1;
		end

		nxt = s;
		byte_inc = s.byte_cnt + 8'd1;
		rx_shift = {s.shreg[6:0], sda_sample};
		mack_nack = (s.byte_cnt >= cfg.transfer_length);

		case (s.phase)
			PH_ST1: begin
				res.sda_drive = 1'b1;
				nxt.phase = PH_ST2;
			end
			PH_ST2: begin
				res.sda_drive = 1'b1;
				res.sda_level = 1'b0;
				nxt.phase = PH_ST3;
			end
			PH_ST3: begin
				res.scl_level = 1'b0;
				res.sda_drive = 1'b1;
				res.sda_level = 1'b0;
				nxt.bit_cnt = '0;
				nxt.wait_cnt = '0;
				nxt.phase = PH_TXL;
				if (s.bit_cnt != 3'd0) begin
					nxt.kind = K_AR;
					nxt.shreg = cfg.device_address | READ_BIT;
				end else begin
					nxt.kind = K_AW;
					nxt.shreg = cfg.device_address;
				end
			end
			PH_RST: begin
				res.scl_level = 1'b0;
				res.sda_drive = 1'b1;
				nxt.bit_cnt = 3'd1;
				nxt.phase = PH_ST1;
			end
			PH_TXL: begin
				res.scl_level = 1'b0;
				res.sda_drive = 1'b1;
				res.sda_level = s.shreg[7];
				nxt.phase = PH_TXH;
			end
			PH_TXH: begin
				res.sda_drive = 1'b1;
				res.sda_level = s.shreg[7];
				nxt.shreg = {s.shreg[6:0], 1'b0};
				if (s.bit_cnt == 3'd7) begin
					nxt.bit_cnt = '0;
					nxt.wait_cnt = '0;
					nxt.phase = PH_TXA;
				end else begin
					nxt.bit_cnt = s.bit_cnt + 3'd1;
					nxt.phase = PH_TXL;
				end
			end
			PH_TXA: begin
				if (s.bit_cnt == 3'd0) begin
					res.scl_level = 1'b0;
					nxt.bit_cnt = 3'd1;
				end else if (sda_sample == 1'b0) begin
					nxt.bit_cnt = '0;
					nxt.wait_cnt = '0;
					case (s.kind)
						K_AW: begin
							nxt.phase = PH_TXL;
							if (cfg.wide_register_address) begin
								nxt.kind = K_RH;
								nxt.shreg = cfg.register_address[15:8];
							end else begin
								nxt.kind = K_RL;
								nxt.shreg = cfg.register_address[7:0];
							end
						end
						K_RH: begin
							nxt.phase = PH_TXL;
							nxt.kind = K_RL;
							nxt.shreg = cfg.register_address[7:0];
						end
						K_RL: begin
							nxt.wait_cnt = s.wait_cnt;
							if (s.read_mode) begin
								nxt.phase = PH_RST;
							end else if (s.byte_cnt >= cfg.transfer_length) begin
								nxt.phase = PH_SP1;
							end else begin
								res.tx_taken = 1'b1;
								nxt.wait_cnt = '0;
								nxt.kind = K_DW;
								nxt.shreg = tx_byte;
								nxt.phase = PH_TXL;
							end
						end
						K_DW: begin
							nxt.byte_cnt = byte_inc;
							if (byte_inc >= cfg.transfer_length) begin
								nxt.wait_cnt = s.wait_cnt;
								nxt.phase = PH_SP1;
							end else begin
								res.tx_taken = 1'b1;
								nxt.shreg = tx_byte;
								nxt.phase = PH_TXL;
							end
						end
						default: begin
							nxt.wait_cnt = s.wait_cnt;
							if (cfg.transfer_length == 8'd0) begin
								nxt.phase = PH_SP1;
							end else begin
								nxt.shreg = '0;
								nxt.phase = PH_RXL;
							end
						end
					endcase
				end else if (s.wait_cnt >= cfg.ack_timeout) begin
					nxt.phase = PH_SP1;
					nxt.bit_cnt = (s.kind != K_DW) ? 3'd1 : 3'd0;
				end else begin
					nxt.wait_cnt = s.wait_cnt + 8'd1;
				end
			end
			PH_RXL: begin
				res.scl_level = 1'b0;
				nxt.phase = PH_RXH;
			end
			PH_RXH: begin
				nxt.shreg = rx_shift;
				if (s.bit_cnt == 3'd7) begin
					res.rx_valid = 1'b1;
					res.rx_byte = rx_shift;
					nxt.byte_cnt = byte_inc;
					nxt.bit_cnt = '0;
					nxt.phase = PH_MAL;
				end else begin
					nxt.bit_cnt = s.bit_cnt + 3'd1;
					nxt.phase = PH_RXL;
				end
			end
			PH_MAL: begin
				res.sda_drive = 1'b1;
				res.sda_level = mack_nack;
				res.scl_level = 1'b0;
				nxt.phase = PH_MAH;
			end
			PH_MAH: begin
				res.sda_drive = 1'b1;
				res.sda_level = mack_nack;
				if (mack_nack) begin
					nxt.phase = PH_SP1;
					nxt.bit_cnt = '0;
				end else begin
					nxt.phase = PH_RXL;
					nxt.bit_cnt = '0;
					nxt.shreg = '0;
				end
			end
			PH_SP1: begin
				res.scl_level = 1'b0;
				res.sda_drive = 1'b1;
				res.sda_level = 1'b0;
				nxt.phase = PH_SP2;
			end
			PH_SP2: begin
				res.sda_drive = 1'b1;
				res.sda_level = 1'b0;
				nxt.phase = PH_SP3;
			end
			PH_SP3: begin
				res.sda_drive = 1'b1;
				res.done_res = 1'b1;
				res.fault = (s.bit_cnt != 3'd0);
				nxt.bit_cnt = '0;
				nxt.phase = PH_IDLE;
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase

		res.busy_res = (nxt.phase != PH_IDLE);
		res.bytes_done = nxt.byte_cnt;
	end

endmodule

@@ src/irm_checker.sv @@
// Port-level assertions for the I2C register access master, bound to the top level.
module irm_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  scl_level,
	input logic                  sda_level,
	input logic                  sda_drive,
	input logic                  tx_taken,
	input logic                  rx_valid,
	input logic                  busy_res,
	input logic                  done_res,
	input logic [7:0]            bytes_done,
	input logic                  fault
);

	a_fault_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> done_res)
		else $error("fault shown without done");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !rx_valid && !tx_taken)
		else $error("done tick still busy or moving data");

	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_drive |-> sda_level)
		else $error("released SDA not reported high");

	a_rx_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> busy_res && scl_level && !sda_drive)
		else $error("read byte outside an active read phase");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bytes_done) && $stable(done_res))
		else $error("stalled item changed");

endmodule

bind i2c_register_access_master irm_checker u_irm_checker (.*);

@@ sim/irm_bus_checker.sv @@
// Bus phase predictor and result comparator for the I2C register access master.
module irm_bus_checker import irm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            action,
	input  logic                  sda_sample,
	input  logic [7:0]            tx_byte,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  scl_level,
	input  logic                  sda_level,
	input  logic                  sda_drive,
	input  logic                  tx_taken,
	input  logic [7:0]            rx_byte,
	input  logic                  rx_valid,
	input  logic                  busy_res,
	input  logic                  done_res,
	input  logic [7:0]            bytes_done,
	input  logic                  fault,
	output int                    failures,
	output int                    outstanding
);

	cfg_t       regs;
	seq_state_t st;
	result_t    bus_ticks[$];
	result_t    want;
	int         mismatch_cnt = 0;
	int         open_cnt = 0;

	assign failures = mismatch_cnt;
	assign outstanding = open_cnt;

	function automatic void load_shift(kind_t k, logic [7:0] v);
		st.shreg = v;
		st.bit_cnt = '0;
		st.wait_cnt = '0;
		st.kind = k;
		st.phase = PH_TXL;
	endfunction

	function automatic void start_stop(logic flag);
		st.phase = PH_SP1;
		st.bit_cnt = {2'b00, flag};
	endfunction

	function automatic logic byte_acked(logic [7:0] txb);
		logic taken;
		taken = 1'b0;
		case (st.kind)
			K_AW: begin
				if (regs.wide_register_address)
					load_shift(K_RH, regs.register_address[15:8]);
				else
					load_shift(K_RL, regs.register_address[7:0]);
			end
			K_RH: load_shift(K_RL, regs.register_address[7:0]);
			K_RL, K_DW: begin
				if (st.kind == K_DW)
					st.byte_cnt = st.byte_cnt + 8'd1;
				if (st.kind == K_RL && st.read_mode) begin
					st.phase = PH_RST;
					st.bit_cnt = '0;
				end else if (st.byte_cnt >= regs.transfer_length) begin
					start_stop(1'b0);
				end else begin
					taken = 1'b1;
					load_shift(K_DW, txb);
				end
			end
			default: begin
				if (regs.transfer_length == 8'd0) begin
					start_stop(1'b0);
				end else begin
					st.phase = PH_RXL;
					st.bit_cnt = '0;
					st.shreg = '0;
				end
			end
		endcase
		return taken;
	endfunction

	function automatic result_t predict_tick(logic [1:0] act, logic sda, logic [7:0] txb);
		result_t r;
		r = '0;
		r.scl_level = 1'b1;
		r.sda_level = 1'b1;
		if (st.phase == PH_IDLE && (act == ACT_WRITE || act == ACT_READ)) begin
			st.read_mode = (act == ACT_READ);
			st.bit_cnt = '0;
			st.byte_cnt = '0;
			st.wait_cnt = '0;
			st.shreg = '0;
			st.phase = PH_ST1;
		end
		case (st.phase)
			PH_ST1: begin
				r.sda_drive = 1'b1;
				st.phase = PH_ST2;
			end
			PH_ST2: begin
				r.sda_drive = 1'b1;
				r.sda_level = 1'b0;
				st.phase = PH_ST3;
			end
			PH_ST3: begin
				r.scl_level = 1'b0;
				r.sda_drive = 1'b1;
				r.sda_level = 1'b0;
				if (st.bit_cnt != 3'd0)
					load_shift(K_AR, regs.device_address | READ_BIT);
				else
					load_shift(K_AW, regs.device_address);
			end
			PH_RST: begin
				r.scl_level = 1'b0;
				r.sda_drive = 1'b1;
				st.bit_cnt = 3'd1;
				st.phase = PH_ST1;
			end
			PH_TXL: begin
				r.scl_level = 1'b0;
				r.sda_drive = 1'b1;
				r.sda_level = st.shreg[7];
				st.phase = PH_TXH;
			end
			PH_TXH: begin
				r.sda_drive = 1'b1;
				r.sda_level = st.shreg[7];
				st.shreg = {st.shreg[6:0], 1'b0};
				if (st.bit_cnt == 3'd7) begin
					st.bit_cnt = '0;
					st.wait_cnt = '0;
					st.phase = PH_TXA;
				end else begin
					st.bit_cnt = st.bit_cnt + 3'd1;
					st.phase = PH_TXL;
				end
			end
			PH_TXA: begin
				if (st.bit_cnt == 3'd0) begin
					r.scl_level = 1'b0;
					st.bit_cnt = 3'd1;
				end else if (!sda) begin
					r.tx_taken = byte_acked(txb);
				end else if (st.wait_cnt >= regs.ack_timeout) begin
					start_stop(st.kind != K_DW);
				end else begin
					st.wait_cnt = st.wait_cnt + 8'd1;
				end
			end
			PH_RXL: begin
				r.scl_level = 1'b0;
				st.phase = PH_RXH;
			end
			PH_RXH: begin
				st.shreg = {st.shreg[6:0], sda};
				if (st.bit_cnt == 3'd7) begin
					r.rx_valid = 1'b1;
					r.rx_byte = st.shreg;
					st.byte_cnt = st.byte_cnt + 8'd1;
					st.bit_cnt = '0;
					st.phase = PH_MAL;
				end else begin
					st.bit_cnt = st.bit_cnt + 3'd1;
					st.phase = PH_RXL;
				end
			end
			PH_MAL, PH_MAH: begin
				r.sda_drive = 1'b1;
				r.sda_level = (st.byte_cnt >= regs.transfer_length);
				if (st.phase == PH_MAL) begin
					r.scl_level = 1'b0;
					st.phase = PH_MAH;
				end else if (r.sda_level) begin
					start_stop(1'b0);
				end else begin
					st.phase = PH_RXL;
					st.bit_cnt = '0;
					st.shreg = '0;
				end
			end
			PH_SP1: begin
				r.scl_level = 1'b0;
				r.sda_drive = 1'b1;
				r.sda_level = 1'b0;
				st.phase = PH_SP2;
			end
			PH_SP2: begin
				r.sda_drive = 1'b1;
				r.sda_level = 1'b0;
				st.phase = PH_SP3;
			end
			PH_SP3: begin
				r.sda_drive = 1'b1;
				r.done_res = 1'b1;
				r.fault = (st.bit_cnt != 3'd0);
				st.bit_cnt = '0;
				st.phase = PH_IDLE;
			end
			default: st.phase = PH_IDLE;
		endcase
		r.busy_res = (st.phase != PH_IDLE);
		r.bytes_done = st.byte_cnt;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			regs.ack_timeout = ACK_TIMEOUT_RESET;
			st.phase = PH_IDLE;
			st.kind = K_AW;
			st.read_mode = 1'b0;
			st.bit_cnt = '0;
			st.shreg = '0;
			st.byte_cnt = '0;
			st.wait_cnt = '0;
			bus_ticks.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEVICE_ADDRESS:   regs.device_address = cfg_data[7:0];
					CFG_REGISTER_ADDRESS: regs.register_address = cfg_data[15:0];
					CFG_WIDE_ADDRESS:     regs.wide_register_address = cfg_data[0];
					CFG_TRANSFER_LENGTH:  regs.transfer_length = cfg_data[7:0];
					CFG_ACK_TIMEOUT:      regs.ack_timeout = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (bus_ticks.size() == 0) begin
					$error("result item with no expected item");
					mismatch_cnt++;
				end else begin
					want = bus_ticks.pop_front();
					check_field("scl_level", want.scl_level, scl_level);
					check_field("sda_level", want.sda_level, sda_level);
					check_field("sda_drive", want.sda_drive, sda_drive);
					check_field("tx_taken", want.tx_taken, tx_taken);
					check_field("rx_byte", want.rx_byte, rx_byte);
					check_field("rx_valid", want.rx_valid, rx_valid);
					check_field("busy_res", want.busy_res, busy_res);
					check_field("done_res", want.done_res, done_res);
					check_field("bytes_done", want.bytes_done, bytes_done);
					check_field("fault", want.fault, fault);
				end
			end
			if (in_valid && in_ready)
				bus_ticks.push_back(predict_tick(action, sda_sample, tx_byte));
		end
		open_cnt = bus_ticks.size();
	end

endmodule

@@ sim/tb_i2c_register_access_master.sv @@
// Testbench top for the I2C register access master: stimulus, handshake pacing and verdict.
module tb_i2c_register_access_master;
	import irm_pkg::*;

	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam int TOTAL_ITEMS = 700;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PRESSURE_AT = 250;
	localparam int PRESSURE_CYCLES = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            action;
	logic                  sda_sample;
	logic [7:0]            tx_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic                  scl_level;
	logic                  sda_level;
	logic                  sda_drive;
	logic                  tx_taken;
	logic [7:0]            rx_byte;
	logic                  rx_valid;
	logic                  busy_res;
	logic                  done_res;
	logic [7:0]            bytes_done;
	logic                  fault;
	int                    failures;
	int                    outstanding;

	int         sent = 0;
	int         stops_seen = 0;
	bit         burst = 1'b0;
	logic [7:0] cur_len = 8'd0;

	i2c_register_access_master dut (.*);
	irm_bus_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		if (out_valid && out_ready && done_res)
			stops_seen++;

	function automatic logic bus_bit(int low_pct);
		return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
	endfunction

	function automatic logic [7:0] data_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [1:0] noise_action();
		case ($urandom_range(0, 2))
			0: return ACT_WRITE;
			1: return ACT_READ;
			default: return ACT_IGNORED;
		endcase
	endfunction

	function automatic logic [15:0] draw_setting(logic [2:0] idx);
		case (idx)
			CFG_DEVICE_ADDRESS:   return 16'($urandom_range(0, 255));
			CFG_REGISTER_ADDRESS: return 16'($urandom_range(0, 65535));
			CFG_WIDE_ADDRESS:     return 16'($urandom_range(0, 1));
			CFG_TRANSFER_LENGTH: begin
				case ($urandom_range(0, 9))
					0: return 16'd255;
					1: return 16'($urandom_range(4, 8));
					default: return 16'($urandom_range(0, 3));
				endcase
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'd0;
					1: return 16'd1;
					2: return 16'd255;
					3: return 16'd250;
					default: return 16'($urandom_range(2, 12));
				endcase
			end
		endcase
	endfunction

	task automatic send_tick(input logic [1:0] act, input logic sda, input logic [7:0] txb);
		int gap;
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sda_sample <= sda;
		tx_byte <= txb;
		do @(posedge clk); while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TRANSFER_LENGTH)
			cur_len = val[7:0];
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [7:0] dev, input logic [15:0] regaddr,
			input logic wide, input logic [7:0] len, input logic [7:0] tmo);
		set_reg(CFG_DEVICE_ADDRESS, {8'h00, dev});
		set_reg(CFG_REGISTER_ADDRESS, regaddr);
		set_reg(CFG_WIDE_ADDRESS, {15'd0, wide});
		set_reg(CFG_TRANSFER_LENGTH, {8'h00, len});
		set_reg(CFG_ACK_TIMEOUT, {8'h00, tmo});
		cfg_we <= 1'b0;
	endtask

	// Begin one transaction and keep ticking until its stop comes back.
	task automatic run_transfer(input logic [1:0] dir, input int low_pct);
		int n;
		int change_at;
		int goal;
		logic [2:0] idx;
		goal = stops_seen + 1;
		if (cur_len == 8'd255)
			change_at = 150;
		else if ($urandom_range(0, 5) == 0)
			change_at = $urandom_range(10, 80);
		else
			change_at = -1;
		send_tick(dir, bus_bit(low_pct), data_byte());
		n = 0;
		while (stops_seen < goal) begin
			if (n == change_at) begin
				idx = (cur_len == 8'd255) ? CFG_TRANSFER_LENGTH : 3'($urandom_range(0, 4));
				drain();
				if (idx == CFG_TRANSFER_LENGTH)
					set_reg(idx, 16'($urandom_range(0, 3)));
				else
					set_reg(idx, draw_setting(idx));
				cfg_we <= 1'b0;
			end
			send_tick(($urandom_range(0, 29) == 0) ? noise_action() : ACT_TICK,
				bus_bit(low_pct), data_byte());
			n++;
		end
	endtask

	initial begin : result_sink
		int gap;
		int taken_cnt;
		bit steady;
		bit held;
		taken_cnt = 0;
		steady = 1'b0;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			if (!held && taken_cnt >= PRESSURE_AT) begin
				gap = PRESSURE_CYCLES;
				held = 1'b1;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 19);
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken_cnt++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int goal_items;
		int low_pct;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEVICE_ADDRESS;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_TICK;
		sda_sample = 1'b1;
		tx_byte = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_tick(ACT_IGNORED, 1'b0, 8'hFF);
		send_tick(ACT_TICK, 1'b1, 8'h00);
		run_transfer(ACT_WRITE, 100);
		drain();
		load_settings(8'hFF, 16'hFFFF, 1'b1, 8'd1, 8'd255);
		run_transfer(ACT_READ, 50);
		drain();
		load_settings(8'h00, 16'h0000, 1'b0, 8'd2, 8'd0);
		run_transfer(ACT_WRITE, 0);
		drain();
		load_settings(8'hA5, 16'h1234, 1'b1, 8'd255, 8'd1);
		run_transfer(ACT_WRITE, 80);

		goal_items = TOTAL_ITEMS;
		while (sent < goal_items) begin
			if ($urandom_range(0, 1) == 0) begin
				drain();
				load_settings(draw_setting(CFG_DEVICE_ADDRESS),
					draw_setting(CFG_REGISTER_ADDRESS),
					draw_setting(CFG_WIDE_ADDRESS),
					draw_setting(CFG_TRANSFER_LENGTH),
					draw_setting(CFG_ACK_TIMEOUT));
			end
			case ($urandom_range(0, 3))
				0: low_pct = 100;
				1: low_pct = 70;
				2: low_pct = 40;
				default: low_pct = 10;
			endcase
			run_transfer(($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE, low_pct);
		end

		drain();
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ i2c_register_access_master.f @@
src/irm_pkg.sv
src/irm_cfg_regs.sv
src/irm_step.sv
src/i2c_register_access_master.sv
src/irm_checker.sv
sim/irm_bus_checker.sv
sim/tb_i2c_register_access_master.sv
